// ----- rtl/assert_macros.svh -----
// Assertion helpers; each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sacs_pkg.sv -----
package sacs_pkg;

    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_CLEAR     = 3'd1;
    localparam logic [2:0] OP_SET       = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_CLOSURE   = 3'd4;
    localparam logic [2:0] OP_REMOVE    = 3'd5;
    localparam logic [2:0] OP_INTRODUCE = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] row_index;
        logic [4:0] col_index;
        logic       edge_value;
        logic [5:0] new_count;
    } in_item_t;

    typedef struct packed {
        logic       edge_bit;
        logic [5:0] vertices_now;
        logic [1:0] status;
    } out_item_t;

endpackage

// ----- rtl/sacs_if.sv -----
interface sacs_in_if import sacs_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sacs_out_if import sacs_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/symmetric_adjacency_closure_store.sv -----
// Channel | Dir | Payload
// req     | in  | operation, row_index, col_index, edge_value, new_count
// rsp     | out | edge_bit, vertices_now, status
//
// Rows are read and written back one at a time through a single row memory.
// Create, clear and rejected items skip the memory; query reads one row, set edge updates two.
// Remove, introduce and closure step through every row below the count.
// Reset clears the count and all row valid bits at once; no sweep.
// A stalled result holds in the output register; the next item waits in the final step.
module symmetric_adjacency_closure_store import sacs_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  logic clk,
    input  logic rst_n,
    sacs_in_if.sink    req,
    sacs_out_if.source rsp
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int W    = MAX_VERTICES;
    localparam int CMPW = 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_PRD  = 3'd3;
    localparam logic [2:0] S_PWR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    state_reg, state_next;
    in_item_t      item_reg, item_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] i_reg, i_next;
    logic [W-1:0]  piv_reg, piv_next;
    logic          bit_reg, bit_next;
    logic [1:0]    stat_reg, stat_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    logic          clear_all, rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [W-1:0]  wr_data, rd_data;

    logic [AW-1:0] r_a, c_a, last_a;
    logic [W-1:0]  mask_r, mask_r1, squeeze, grow;
    logic          k_last;
    logic          acc;

    sacs_row_mem #(.ROWS(MAX_VERTICES), .W(W)) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data   (rd_data)
    );

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign r_a     = AW'(item_reg.row_index);
    assign c_a     = AW'(item_reg.col_index);
    assign last_a  = AW'(cnt_reg - CW'(1));
    assign k_last  = (k_reg == last_a);
    assign mask_r  = (W'(1) << r_a) - W'(1);
    assign mask_r1 = {mask_r[W-2:0], 1'b1};
    assign squeeze = (rd_data & mask_r) | ((rd_data >> 1) & ~mask_r);
    assign grow    = (rd_data & mask_r) | ((rd_data << 1) & ~mask_r1);

    always_comb
    begin
        rd_addr = k_reg;
        unique case (item_reg.operation)
            OP_SET:       rd_addr = (k_reg == '0) ? r_a : c_a;
            OP_QUERY:     rd_addr = r_a;
            OP_REMOVE:    rd_addr = (k_reg < r_a || k_last) ? k_reg : k_reg + AW'(1);
            OP_INTRODUCE: rd_addr = (k_reg > r_a) ? k_reg - AW'(1) : k_reg;
            default:      rd_addr = k_reg;
        endcase
        if (state_reg == S_PRD)
        begin
            rd_addr = i_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        piv_next       = piv_reg;
        bit_next       = bit_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        clear_all      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    item_next  = req.data;
                    bit_next   = 1'b0;
                    stat_next  = ST_OK;
                    k_next     = '0;
                    i_next     = '0;
                    state_next = S_FIN;
                    unique case (req.data.operation)
                        OP_CREATE:
                        begin
                            if (CMPW'(req.data.new_count) > CMPW'(MAX_VERTICES))
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                clear_all = 1'b1;
                                cnt_next  = CW'(req.data.new_count);
                            end
                        end
                        OP_CLEAR:
                        begin
                            clear_all = 1'b1;
                        end
                        OP_SET, OP_QUERY:
                        begin
                            if (CMPW'(req.data.row_index) >= CMPW'(cnt_reg) ||
                                CMPW'(req.data.col_index) >= CMPW'(cnt_reg))
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_CLOSURE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = S_PRD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = ST_LIMIT;
                            end
                            else if (CMPW'(req.data.row_index) >= CMPW'(cnt_reg))
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_INTRODUCE:
                        begin
                            if (CMPW'(cnt_reg) >= CMPW'(MAX_VERTICES))
                            begin
                                stat_next = ST_LIMIT;
                            end
                            else if (CMPW'(req.data.row_index) > CMPW'(cnt_reg))
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                k_next     = AW'(cnt_reg);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_PRD:
            begin
                rd_en      = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                piv_next   = rd_data;
                k_next     = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                unique case (item_reg.operation)
                    OP_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = (k_reg == '0) ? r_a : c_a;
                        wr_data = item_reg.edge_value
                                ? rd_data | (W'(1) << ((k_reg == '0) ? c_a : r_a))
                                : rd_data & ~(W'(1) << ((k_reg == '0) ? c_a : r_a));
                        if (k_reg == '0)
                        begin
                            k_next     = AW'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    OP_QUERY:
                    begin
                        bit_next   = rd_data[c_a];
                        state_next = S_FIN;
                    end
                    OP_CLOSURE:
                    begin
                        wr_en   = rd_data[i_reg];
                        wr_data = rd_data | piv_reg;
                        if (!k_last)
                        begin
                            k_next     = k_reg + AW'(1);
                            state_next = S_RD;
                        end
                        else if (i_reg == last_a)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            i_next     = i_reg + AW'(1);
                            state_next = S_PRD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        wr_en   = 1'b1;
                        wr_data = k_last ? '0 : squeeze;
                        if (k_last)
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = k_reg + AW'(1);
                            state_next = S_RD;
                        end
                    end
                    OP_INTRODUCE:
                    begin
                        wr_en   = 1'b1;
                        wr_data = (k_reg == r_a) ? '0 : grow;
                        if (k_reg == '0)
                        begin
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = k_reg - AW'(1);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.edge_bit     = bit_reg;
                    out_next.vertices_now = 6'(cnt_reg);
                    out_next.status       = stat_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        piv_reg  <= piv_next;
        bit_reg  <= bit_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMP(a_cnt_bound, 1'b1, CMPW'(cnt_reg) <= CMPW'(MAX_VERTICES))
    `ASSERT_NXT(a_acc_busy, acc, state_reg != S_IDLE)
    `ASSERT_IMP(a_wr_state, wr_en, state_reg == S_WR)
    `ASSERT_IMP(a_fin_load, state_reg == S_FIN && !out_valid_reg, state_next == S_IDLE)

endmodule

// ----- rtl/sacs_row_mem.sv -----
module sacs_row_mem #(
    parameter int ROWS = 32,
    parameter int W    = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear_all,
    input  logic                    rd_en,
    input  logic [$clog2(ROWS)-1:0] rd_addr,
    input  logic                    wr_en,
    input  logic [$clog2(ROWS)-1:0] wr_addr,
    input  logic [W-1:0]            wr_data,
    output logic [W-1:0]            rd_data
);

    logic [W-1:0]    ram [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [W-1:0]    q_reg;
    logic            q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= ram[rd_addr];
        end
    end

    // A row never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule
